### hdl/clock_aging_page_replacer_assert.svh
// Assertion macros shared by the replacer RTL
`ifndef CLOCK_AGING_PAGE_REPLACER_ASSERT_SVH
`define CLOCK_AGING_PAGE_REPLACER_ASSERT_SVH

// Same-cycle implication, off during reset
`define CAPR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off during reset
`define CAPR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/capr_pkg.sv
`default_nettype none
package capr_pkg;
  localparam int FRAMES    = 64;
  localparam int IDX_W     = 6;
  localparam int CNT_W     = 7;
  localparam int PAGE_BITS = 20;
  localparam int AGE_W     = 32;
  localparam int NBITS_W   = 6;
  localparam int IVL_W     = 10;
  localparam int CFG_W     = 10;

  localparam logic [1:0] REG_FRAMES   = 2'd0;
  localparam logic [1:0] REG_REF_BITS = 2'd1;
  localparam logic [1:0] REG_INTERVAL = 2'd2;

  localparam logic [1:0] OP_NONE  = 2'd0;
  localparam logic [1:0] OP_HIT   = 2'd1;
  localparam logic [1:0] OP_LOAD  = 2'd2;
  localparam logic [1:0] OP_HALVE = 2'd3;

  typedef struct packed {
    logic [PAGE_BITS-1:0] page_id;
    logic                 is_write;
  } in_word_t;

  typedef struct packed {
    logic                 hit;
    logic                 fault;
    logic                 write_back;
    logic [IDX_W-1:0]     frame_used;
    logic [PAGE_BITS-1:0] evicted_page;
    logic                 evicted_valid;
    logic [31:0]          fault_total;
    logic [31:0]          write_back_total;
  } out_word_t;

  // Broadcast from the controller to every frame cell
  typedef struct packed {
    logic                 shift;
    logic [1:0]           op;
    logic [IDX_W-1:0]     sel;
    logic [PAGE_BITS-1:0] page;
    logic                 wr;
    logic [AGE_W-1:0]     top;
    logic [CNT_W-1:0]     count;
  } cell_cmd_t;

  // Status returned by each frame cell
  typedef struct packed {
    logic                 match;
    logic                 valid;
    logic                 active;
    logic                 dirty;
    logic                 zero;
    logic [PAGE_BITS-1:0] tag;
  } cell_stat_t;
endpackage
`default_nettype wire

### hdl/clock_aging_page_replacer.sv
// Clock page replacer with aging registers. One cell per frame holds tag, valid,
// dirty and age; a controller broadcasts each step to the row. A hit or a fill of
// an empty frame passes accept (tag match) and resolve, which waits for a free output.
// On a fault with a full table the hand sweeps, halving one register per cycle, and
// evicts the first frame with zero age once the output is free. The result is held in
// an output register until taken; a new word is accepted only when the block is idle.
`default_nettype none
module clock_aging_page_replacer import capr_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_we,
  input  wire logic [1:0] cfg_index,
  input  wire logic [CFG_W-1:0] cfg_data,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire in_word_t   in_data,
  output logic            out_valid,
  input  wire logic       out_ready,
  output out_word_t       out_data
);
  `include "clock_aging_page_replacer_assert.svh"

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_LOOK  = 2'd1;
  localparam logic [1:0] ST_SWEEP = 2'd2;

  logic [CNT_W-1:0]   frames_in_use;
  logic [NBITS_W-1:0] ref_reg_bits;
  logic [IVL_W-1:0]   shift_interval;

  logic [1:0]           state, state_next;
  logic [IDX_W-1:0]     hand, hand_next;
  logic [IVL_W-1:0]     interval_count, interval_next;
  logic [31:0]          fault_count, fault_next;
  logic [31:0]          wb_count, wb_next;
  logic [PAGE_BITS-1:0] page_r;
  logic                 wr_r;
  logic [CNT_W-1:0]     count_r, count_c;
  logic [AGE_W-1:0]     top_r, top_c;
  logic [NBITS_W-1:0]   nbits;

  cell_cmd_t         cmd;
  cell_stat_t        stat [FRAMES];
  logic [FRAMES-1:0] match_v, empty_v;
  logic              any_match, any_empty;
  logic [IDX_W-1:0]  match_idx, empty_idx, hand_inc;
  logic              out_free, done;
  out_word_t         res;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      frames_in_use  <= CNT_W'(64);
      ref_reg_bits   <= NBITS_W'(8);
      shift_interval <= IVL_W'(10);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FRAMES:   frames_in_use  <= cfg_data[CNT_W-1:0];
        REG_REF_BITS: ref_reg_bits   <= cfg_data[NBITS_W-1:0];
        REG_INTERVAL: shift_interval <= cfg_data[IVL_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp frame count and register width
  always_comb begin
    if (frames_in_use == '0) count_c = CNT_W'(1);
    else if (frames_in_use > CNT_W'(FRAMES)) count_c = CNT_W'(FRAMES);
    else count_c = frames_in_use;
    if (ref_reg_bits == '0) nbits = NBITS_W'(1);
    else if (ref_reg_bits > NBITS_W'(AGE_W)) nbits = NBITS_W'(AGE_W);
    else nbits = ref_reg_bits;
    top_c = AGE_W'(1) << (nbits - NBITS_W'(1));
  end

  // Row of frame cells
  for (genvar g = 0; g < FRAMES; g++) begin : g_cell
    capr_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .idx  (IDX_W'(g)),
      .cmd  (cmd),
      .stat (stat[g])
    );
    assign match_v[g] = stat[g].match;
    assign empty_v[g] = !stat[g].valid && stat[g].active;
  end

  // Lowest matching and lowest empty frame
  always_comb begin
    any_match = 1'b0;
    any_empty = 1'b0;
    match_idx = '0;
    empty_idx = '0;
    for (int i = FRAMES - 1; i >= 0; i--) begin
      if (match_v[i]) begin
        any_match = 1'b1;
        match_idx = IDX_W'(i);
      end
      if (empty_v[i]) begin
        any_empty = 1'b1;
        empty_idx = IDX_W'(i);
      end
    end
  end

  assign hand_inc = ({1'b0, hand} + CNT_W'(1) == count_r) ? '0 : hand + IDX_W'(1);
  assign out_free = !out_valid || out_ready;
  assign in_ready = state == ST_IDLE;

  // Step controller
  always_comb begin
    state_next    = state;
    hand_next     = hand;
    interval_next = interval_count;
    fault_next    = fault_count;
    wb_next       = wb_count;
    done          = 1'b0;
    cmd.shift     = 1'b0;
    cmd.op        = OP_NONE;
    cmd.sel       = hand;
    cmd.page      = page_r;
    cmd.wr        = wr_r;
    cmd.top       = top_r;
    cmd.count     = count_r;
    res           = '0;
    res.frame_used = hand;
    case (state)
      ST_IDLE: begin
        cmd.page  = in_data.page_id;
        cmd.count = count_c;
        if (in_valid) begin
          cmd.shift = interval_count >= shift_interval;
          if (cmd.shift) interval_next = '0;
          if ({1'b0, hand} >= count_c) hand_next = '0;
          state_next = ST_LOOK;
        end
      end
      ST_LOOK: begin
        if (any_match) begin
          if (out_free) begin
            cmd.op  = OP_HIT;
            cmd.sel = match_idx;
            res.hit = 1'b1;
            res.frame_used = match_idx;
            done = 1'b1;
          end
        end else if (any_empty) begin
          if (out_free) begin
            cmd.op  = OP_LOAD;
            cmd.sel = empty_idx;
            if (empty_idx == hand) hand_next = hand_inc;
            fault_next = fault_count + 32'd1;
            res.fault = 1'b1;
            res.frame_used = empty_idx;
            done = 1'b1;
          end
        end else begin
          state_next = ST_SWEEP;
        end
      end
      ST_SWEEP: begin
        if (stat[hand].zero) begin
          if (out_free) begin
            cmd.op    = OP_LOAD;
            hand_next = hand_inc;
            fault_next = fault_count + 32'd1;
            if (stat[hand].dirty) wb_next = wb_count + 32'd1;
            res.fault         = 1'b1;
            res.write_back    = stat[hand].dirty;
            res.evicted_valid = 1'b1;
            res.evicted_page  = stat[hand].tag;
            done = 1'b1;
          end
        end else begin
          cmd.op    = OP_HALVE;
          hand_next = hand_inc;
        end
      end
      default: state_next = ST_IDLE;
    endcase
    if (done) begin
      interval_next = interval_count + IVL_W'(1);
      state_next    = ST_IDLE;
    end
    res.fault_total      = fault_next;
    res.write_back_total = wb_next;
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      hand           <= '0;
      interval_count <= '0;
      fault_count    <= '0;
      wb_count       <= '0;
      out_valid      <= 1'b0;
    end else begin
      state          <= state_next;
      hand           <= hand_next;
      interval_count <= interval_next;
      fault_count    <= fault_next;
      wb_count       <= wb_next;
      if (done) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  // Latch the word and step settings; hold the result
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_valid) begin
      page_r  <= in_data.page_id;
      wr_r    <= in_data.is_write;
      count_r <= count_c;
      top_r   <= top_c;
    end
    if (done) out_data <= res;
  end

  `CAPR_ASSERT_NOW(a_hit_xor_fault, out_valid, out_data.hit != out_data.fault, "hit/fault")
  `CAPR_ASSERT_NOW(a_wb_evicts, out_valid && out_data.write_back, out_data.evicted_valid, "wb")
  `CAPR_ASSERT_NOW(a_hand_range, state != ST_IDLE, {1'b0, hand} < count_r, "hand range")
  `CAPR_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "accepted while busy")
endmodule
`default_nettype wire

### hdl/capr_cell.sv
`default_nettype none
module capr_cell import capr_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic [IDX_W-1:0] idx,
  input  wire cell_cmd_t  cmd,
  output cell_stat_t      stat
);
  logic [PAGE_BITS-1:0] tag;
  logic                 valid;
  logic                 dirty;
  logic [AGE_W-1:0]     age;
  logic                 match;
  logic                 active;
  logic                 sel;

  assign active = {1'b0, idx} < cmd.count;
  assign sel    = cmd.sel == idx;

  // Tag, valid, dirty and registered match; tag needs no reset
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      dirty <= 1'b0;
      match <= 1'b0;
    end else begin
      match <= valid && active && (tag == cmd.page);
      if (sel && cmd.op == OP_HIT && cmd.wr) dirty <= 1'b1;
      if (sel && cmd.op == OP_LOAD) begin
        valid <= 1'b1;
        dirty <= cmd.wr;
      end
    end
    if (sel && cmd.op == OP_LOAD) tag <= cmd.page;
  end

  // Aging register: global shift, hit mark, load, sweep halve
  always_ff @(posedge clk) begin
    if (rst) begin
      age <= '0;
    end else if (cmd.shift) begin
      if (valid && active) age <= age >> 1;
    end else if (sel) begin
      case (cmd.op)
        OP_HIT:   age <= age | cmd.top;
        OP_LOAD:  age <= cmd.top;
        OP_HALVE: age <= age >> 1;
        default:  age <= age;
      endcase
    end
  end

  assign stat.match  = match;
  assign stat.valid  = valid;
  assign stat.active = active;
  assign stat.dirty  = dirty;
  assign stat.zero   = age == '0;
  assign stat.tag    = tag;
endmodule
`default_nettype wire
